// ===== rtl/core/itpd_pkg.sv =====
`default_nettype none

package itpd_pkg;

    localparam int unsigned PRESCALE_W = 7;
    localparam int unsigned PAYLOAD_W  = 32;
    localparam int unsigned HIGH_W     = 38;
    localparam int unsigned DELTA_W    = PAYLOAD_W + PRESCALE_W;
    localparam int unsigned TS_W       = 64;
    localparam int unsigned GTS_SHIFT  = 26;

    // action codes
    localparam logic [1:0] ACT_PACKET = 2'd0;
    localparam logic [1:0] ACT_EOT    = 2'd1;
    localparam logic [1:0] ACT_RESET  = 2'd2;

    // packet kinds; anything above PK_LOCAL_TS is bad or reserved
    localparam logic [3:0] PK_NOTSYNC   = 4'd0;
    localparam logic [3:0] PK_ASYNC     = 4'd1;
    localparam logic [3:0] PK_INC_EOT   = 4'd2;
    localparam logic [3:0] PK_DWT       = 4'd3;
    localparam logic [3:0] PK_SWIT      = 4'd4;
    localparam logic [3:0] PK_EXTENSION = 4'd5;
    localparam logic [3:0] PK_OVERFLOW  = 4'd6;
    localparam logic [3:0] PK_GTS1      = 4'd7;
    localparam logic [3:0] PK_GTS2      = 4'd8;
    localparam logic [3:0] PK_LOCAL_TS  = 4'd9;

    localparam logic [4:0] EXT_PAGE_CODE = 5'h02;
    localparam logic [2:0] ITK_LOCAL_BASE = 3'd2;

    localparam logic [TS_W-1:0] GTS_MASK_1 = 64'h0000_0000_0000_007F;
    localparam logic [TS_W-1:0] GTS_MASK_2 = 64'h0000_0000_0000_3FFF;
    localparam logic [TS_W-1:0] GTS_MASK_3 = 64'h0000_0000_001F_FFFF;
    localparam logic [TS_W-1:0] GTS_MASK_4 = 64'h0000_0000_03FF_FFFF;

    typedef enum logic [1:0] {
        SYNC_NONE   = 2'd0,
        SYNC_WAIT   = 2'd1,
        SYNC_DECODE = 2'd2
    } sync_state_t;

    typedef enum logic [1:0] {
        CAUSE_INIT  = 2'd0,
        CAUSE_RESET = 2'd1,
        CAUSE_BAD   = 2'd2,
        CAUSE_EOT   = 2'd3
    } cause_t;

    typedef enum logic [1:0] {
        IK_NO_SYNC = 2'd0,
        IK_EOT     = 2'd1,
        IK_ITM     = 2'd2,
        IK_FATAL   = 2'd3
    } item_kind_t;

    typedef enum logic [2:0] {
        ITK_SWIT         = 3'd0,
        ITK_DWT          = 3'd1,
        ITK_TS_SYNC      = 3'd2,
        ITK_TS_DELAY     = 3'd3,
        ITK_TS_PKT_DELAY = 3'd4,
        ITK_TS_PKT_TS    = 3'd5,
        ITK_TS_GLOBAL    = 3'd6
    } itm_kind_t;

    // packet held in the input register, with its prescaled delta
    typedef struct packed {
        logic [1:0]           action;
        logic [3:0]           packet_kind;
        logic [7:0]           source_id;
        logic [PAYLOAD_W-1:0] payload;
        logic [2:0]           payload_bytes;
        logic [HIGH_W-1:0]    high_value;
        logic [DELTA_W-1:0]   scaled_delta;
    } held_pkt_t;

    typedef struct packed {
        logic [1:0]           item_kind;
        logic [1:0]           unsync_reason;
        logic [2:0]           itm_kind;
        logic [2:0]           out_size;
        logic [PAYLOAD_W-1:0] out_value;
        logic [7:0]           out_source;
        logic                 overflow_seen;
        logic [TS_W-1:0]      timestamp;
        logic                 timestamp_valid;
        logic                 freq_changed;
    } result_t;

    function automatic logic [TS_W-1:0] gts_low_mask(input logic [2:0] nbytes);
        logic [TS_W-1:0] mask;
        case (nbytes)
            3'd0, 3'd1: mask = GTS_MASK_1;
            3'd2:       mask = GTS_MASK_2;
            3'd3:       mask = GTS_MASK_3;
            default:    mask = GTS_MASK_4;
        endcase
        return mask;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/itpd_if.sv =====
`default_nettype none

interface itpd_pkt_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      action;
    logic [3:0]                      packet_kind;
    logic [7:0]                      source_id;
    logic [itpd_pkg::PAYLOAD_W-1:0]  payload;
    logic [2:0]                      payload_bytes;
    logic [itpd_pkg::HIGH_W-1:0]     high_value;

    modport source (
        output valid, action, packet_kind, source_id, payload, payload_bytes, high_value,
        input  ready
    );
    modport sink (
        input  valid, action, packet_kind, source_id, payload, payload_bytes, high_value,
        output ready
    );
endinterface

interface itpd_item_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      item_kind;
    logic [1:0]                      unsync_reason;
    logic [2:0]                      itm_kind;
    logic [2:0]                      out_size;
    logic [itpd_pkg::PAYLOAD_W-1:0]  out_value;
    logic [7:0]                      out_source;
    logic                            overflow_seen;
    logic [itpd_pkg::TS_W-1:0]       timestamp;
    logic                            timestamp_valid;
    logic                            freq_changed;

    modport source (
        output valid, item_kind, unsync_reason, itm_kind, out_size, out_value,
               out_source, overflow_seen, timestamp, timestamp_valid, freq_changed,
        input  ready
    );
    modport sink (
        input  valid, item_kind, unsync_reason, itm_kind, out_size, out_value,
               out_source, overflow_seen, timestamp, timestamp_valid, freq_changed,
        output ready
    );
endinterface

interface itpd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [itpd_pkg::PRESCALE_W-1:0]  data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/itm_trace_packet_decoder.sv =====
// Path from packet accept to result valid: input register, then result register.
// Throughput: one packet per cycle unless the result side stalls; the prescale multiply
// sits in the input register stage and the 64-bit local time add in the decode stage,
// so neither limits the rate. Packets that produce no item cause no result-side bubble.
// Reset (rst_n, async, active low): no sync, cause init, timestamps and page zero,
// waiting for a high timestamp part, prescale 1, both stages empty.
`default_nettype none

module itm_trace_packet_decoder (
    input  wire logic    clk,
    input  wire logic    rst_n,
    itpd_pkt_if.sink     pkt,
    itpd_cfg_if.sink     cfg,
    itpd_item_if.source  item
);

    logic                 advance;
    logic                 held_valid;
    itpd_pkg::held_pkt_t  held;

    itpd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt        (pkt),
        .cfg        (cfg),
        .advance    (advance),
        .held_valid (held_valid),
        .held       (held)
    );

    itpd_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .held_valid (held_valid),
        .held       (held),
        .advance    (advance),
        .item       (item)
    );

endmodule

`default_nettype wire

// ===== rtl/core/itpd_in_stage.sv =====
`default_nettype none

module itpd_in_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    itpd_pkt_if.sink           pkt,
    itpd_cfg_if.sink           cfg,
    input  wire logic          advance,
    output logic               held_valid,
    output itpd_pkg::held_pkt_t held
);

    logic [itpd_pkg::PRESCALE_W-1:0] prescale_reg;
    logic                            valid_reg;
    logic                            valid_next;
    itpd_pkg::held_pkt_t             held_reg;
    logic                            accept;

    assign cfg.ready  = 1'b1;
    assign pkt.ready  = !valid_reg || advance;
    assign accept     = pkt.valid && pkt.ready;
    assign held_valid = valid_reg;
    assign held       = held_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= itpd_pkg::PRESCALE_W'(1);
            valid_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg.valid && cfg.ready)
            begin
                prescale_reg <= cfg.data;
            end
        end
    end

    // scale the delta here so the decode stage only has the 64-bit add
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg.action        <= pkt.action;
            held_reg.packet_kind   <= pkt.packet_kind;
            held_reg.source_id     <= pkt.source_id;
            held_reg.payload       <= pkt.payload;
            held_reg.payload_bytes <= pkt.payload_bytes;
            held_reg.high_value    <= pkt.high_value;
            held_reg.scaled_delta  <= itpd_pkg::DELTA_W'(pkt.payload)
                                      * itpd_pkg::DELTA_W'(prescale_reg);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/itpd_decode.sv =====
`default_nettype none

module itpd_decode (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 held_valid,
    input  wire itpd_pkg::held_pkt_t  held,
    output logic                      advance,
    itpd_item_if.source               item
);

    itpd_pkg::sync_state_t        sync_reg, sync_next;
    itpd_pkg::cause_t             cause_reg, cause_next;
    logic [itpd_pkg::TS_W-1:0]    local_reg, local_next;
    logic [itpd_pkg::TS_W-1:0]    global_reg, global_next;
    logic [7:0]                   page_reg, page_next;
    logic                         await_reg, await_next;
    logic                         ovf_reg, ovf_next;
    logic                         freq_reg, freq_next;

    logic                         out_valid_reg, out_valid_next;
    itpd_pkg::result_t            res_reg, res;
    logic                         emit;

    logic [itpd_pkg::TS_W-1:0]    gts1_time;
    logic [itpd_pkg::TS_W-1:0]    gts2_time;
    logic [itpd_pkg::TS_W-1:0]    local_sum;
    logic                         gts1_await;
    logic                         gts1_freq;

    assign advance = held_valid && (!out_valid_reg || item.ready);

    assign gts1_time  = (global_reg & ~itpd_pkg::gts_low_mask(held.payload_bytes))
                        | itpd_pkg::TS_W'(held.payload);
    assign gts2_time  = (global_reg & itpd_pkg::GTS_MASK_4)
                        | {held.high_value, itpd_pkg::GTS_SHIFT'(0)};
    assign local_sum  = local_reg + itpd_pkg::TS_W'(held.scaled_delta);
    assign gts1_await = await_reg || held.source_id[1];
    assign gts1_freq  = freq_reg || held.source_id[0];

    always_comb
    begin
        sync_next   = sync_reg;
        cause_next  = cause_reg;
        local_next  = local_reg;
        global_next = global_reg;
        page_next   = page_reg;
        await_next  = await_reg;
        ovf_next    = ovf_reg;
        freq_next   = freq_reg;
        emit        = 1'b0;
        res         = '0;

        if (advance)
        begin
            case (held.action)
                itpd_pkg::ACT_EOT:
                begin
                    emit              = 1'b1;
                    res.item_kind     = itpd_pkg::IK_EOT;
                    res.unsync_reason = itpd_pkg::CAUSE_EOT;
                end
                itpd_pkg::ACT_RESET:
                begin
                    cause_next = itpd_pkg::CAUSE_RESET;
                end
                itpd_pkg::ACT_PACKET:
                begin
                    if (sync_reg == itpd_pkg::SYNC_DECODE)
                    begin
                        case (held.packet_kind)
                            itpd_pkg::PK_NOTSYNC:
                            begin
                                sync_next   = itpd_pkg::SYNC_NONE;
                                local_next  = '0;
                                global_next = '0;
                                page_next   = '0;
                                await_next  = 1'b1;
                                ovf_next    = 1'b0;
                                freq_next   = 1'b0;
                            end
                            itpd_pkg::PK_ASYNC, itpd_pkg::PK_INC_EOT:
                            begin
                            end
                            itpd_pkg::PK_DWT:
                            begin
                                emit              = 1'b1;
                                res.item_kind     = itpd_pkg::IK_ITM;
                                res.itm_kind      = itpd_pkg::ITK_DWT;
                                res.out_size      = held.payload_bytes;
                                res.out_value     = held.payload;
                                res.out_source    = held.source_id;
                                res.overflow_seen = ovf_reg;
                                ovf_next          = 1'b0;
                            end
                            itpd_pkg::PK_SWIT:
                            begin
                                emit              = 1'b1;
                                res.item_kind     = itpd_pkg::IK_ITM;
                                res.itm_kind      = itpd_pkg::ITK_SWIT;
                                res.out_size      = held.payload_bytes;
                                res.out_value     = held.payload;
                                res.out_source    = {page_reg[2:0], held.source_id[4:0]};
                                res.overflow_seen = ovf_reg;
                                ovf_next          = 1'b0;
                            end
                            itpd_pkg::PK_EXTENSION:
                            begin
                                if (!held.source_id[7]
                                    && held.source_id[4:0] == itpd_pkg::EXT_PAGE_CODE)
                                begin
                                    page_next = held.payload[7:0];
                                end
                            end
                            itpd_pkg::PK_OVERFLOW:
                            begin
                                local_next = '0;
                                ovf_next   = 1'b1;
                            end
                            itpd_pkg::PK_GTS1:
                            begin
                                global_next = gts1_time;
                                await_next  = gts1_await;
                                freq_next   = gts1_freq;
                                // hold the item back while a high part is awaited; source bit 1 sets the wait again
                                if (!gts1_await)
                                begin
                                    emit                = 1'b1;
                                    res.item_kind       = itpd_pkg::IK_ITM;
                                    res.itm_kind        = itpd_pkg::ITK_TS_GLOBAL;
                                    res.overflow_seen   = ovf_reg;
                                    res.timestamp       = gts1_time;
                                    res.timestamp_valid = 1'b1;
                                    res.freq_changed    = gts1_freq;
                                    ovf_next            = 1'b0;
                                    freq_next           = 1'b0;
                                end
                            end
                            itpd_pkg::PK_GTS2:
                            begin
                                global_next         = gts2_time;
                                await_next          = 1'b0;
                                freq_next           = 1'b0;
                                ovf_next            = 1'b0;
                                emit                = 1'b1;
                                res.item_kind       = itpd_pkg::IK_ITM;
                                res.itm_kind        = itpd_pkg::ITK_TS_GLOBAL;
                                res.overflow_seen   = ovf_reg;
                                res.timestamp       = gts2_time;
                                res.timestamp_valid = 1'b1;
                                res.freq_changed    = freq_reg;
                            end
                            itpd_pkg::PK_LOCAL_TS:
                            begin
                                local_next          = local_sum;
                                ovf_next            = 1'b0;
                                emit                = 1'b1;
                                res.item_kind       = itpd_pkg::IK_ITM;
                                res.itm_kind        = itpd_pkg::ITK_LOCAL_BASE
                                                      + {1'b0, held.source_id[1:0]};
                                res.out_size        = held.payload_bytes;
                                res.out_value       = held.payload;
                                res.overflow_seen   = ovf_reg;
                                res.timestamp       = local_sum;
                                res.timestamp_valid = 1'b1;
                            end
                            default:
                            begin
                                // bad or reserved packet: drop sync and report
                                cause_next        = itpd_pkg::CAUSE_BAD;
                                sync_next         = itpd_pkg::SYNC_NONE;
                                local_next        = '0;
                                global_next       = '0;
                                page_next         = '0;
                                await_next        = 1'b1;
                                ovf_next          = 1'b0;
                                freq_next         = 1'b0;
                                emit              = 1'b1;
                                res.item_kind     = itpd_pkg::IK_FATAL;
                                res.unsync_reason = itpd_pkg::CAUSE_BAD;
                            end
                        endcase
                    end
                    else
                    begin
                        if (sync_reg == itpd_pkg::SYNC_NONE)
                        begin
                            emit              = 1'b1;
                            res.item_kind     = itpd_pkg::IK_NO_SYNC;
                            res.unsync_reason = cause_reg;
                            sync_next         = itpd_pkg::SYNC_WAIT;
                        end
                        if (held.packet_kind == itpd_pkg::PK_ASYNC)
                        begin
                            sync_next = itpd_pkg::SYNC_DECODE;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = emit;
        end
        else if (item.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg      <= itpd_pkg::SYNC_NONE;
            cause_reg     <= itpd_pkg::CAUSE_INIT;
            local_reg     <= '0;
            global_reg    <= '0;
            page_reg      <= '0;
            await_reg     <= 1'b1;
            ovf_reg       <= 1'b0;
            freq_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sync_reg      <= sync_next;
            cause_reg     <= cause_next;
            local_reg     <= local_next;
            global_reg    <= global_next;
            page_reg      <= page_next;
            await_reg     <= await_next;
            ovf_reg       <= ovf_next;
            freq_reg      <= freq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            res_reg <= res;
        end
    end

    assign item.valid           = out_valid_reg;
    assign item.item_kind       = res_reg.item_kind;
    assign item.unsync_reason   = res_reg.unsync_reason;
    assign item.itm_kind        = res_reg.itm_kind;
    assign item.out_size        = res_reg.out_size;
    assign item.out_value       = res_reg.out_value;
    assign item.out_source      = res_reg.out_source;
    assign item.overflow_seen   = res_reg.overflow_seen;
    assign item.timestamp       = res_reg.timestamp;
    assign item.timestamp_valid = res_reg.timestamp_valid;
    assign item.freq_changed    = res_reg.freq_changed;

endmodule

`default_nettype wire

// ===== rtl/core/itpd_checker.sv =====
`default_nettype none

module itpd_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            item_valid,
    input  wire logic                            item_ready,
    input  wire logic [1:0]                      item_kind,
    input  wire logic [2:0]                      itm_kind,
    input  wire logic [itpd_pkg::PAYLOAD_W-1:0]  out_value,
    input  wire logic                            overflow_seen,
    input  wire logic [itpd_pkg::TS_W-1:0]       timestamp,
    input  wire logic                            timestamp_valid,
    input  wire logic                            freq_changed
);

    a_stall_keeps_valid: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid)
        else $error("result dropped while stalled");

    a_stall_keeps_data: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> $stable(item_kind) && $stable(timestamp)
                                      && $stable(out_value))
        else $error("result changed while stalled");

    a_non_itm_clean: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_kind != itpd_pkg::IK_ITM |->
            !timestamp_valid && !overflow_seen && !freq_changed
            && timestamp == '0 && out_value == '0)
        else $error("status item carries trace fields");

    a_freq_on_global: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && freq_changed |->
            item_kind == itpd_pkg::IK_ITM && itm_kind == itpd_pkg::ITK_TS_GLOBAL
            && timestamp_valid)
        else $error("frequency change flag outside a global timestamp");

    a_ts_only_on_time_items: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && timestamp_valid |->
            item_kind == itpd_pkg::IK_ITM && itm_kind != itpd_pkg::ITK_SWIT
            && itm_kind != itpd_pkg::ITK_DWT)
        else $error("timestamp on a payload item");

endmodule

bind itm_trace_packet_decoder itpd_checker u_itpd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item.valid),
    .item_ready      (item.ready),
    .item_kind       (item.item_kind),
    .itm_kind        (item.itm_kind),
    .out_value       (item.out_value),
    .overflow_seen   (item.overflow_seen),
    .timestamp       (item.timestamp),
    .timestamp_valid (item.timestamp_valid),
    .freq_changed    (item.freq_changed)
);

`default_nettype wire

// ===== sim/tb_itm_trace_packet_decoder.sv =====
`timescale 1ns / 1ps

// codes the package leaves unnamed
localparam logic [1:0] ACT_UNUSED      = 2'd3;
localparam logic [3:0] PK_BAD          = 4'd10;
localparam logic [3:0] PK_RESERVED_LOW = 4'd11;
localparam logic [3:0] PK_RESERVED_TOP = 4'd15;
localparam int         GTS1_FREQ_BIT   = 0;
localparam int         GTS1_WAIT_BIT   = 1;

typedef struct {
    logic [1:0]                     action;
    logic [3:0]                     kind;
    logic [7:0]                     source;
    logic [itpd_pkg::PAYLOAD_W-1:0] payload;
    logic [2:0]                     nbytes;
    logic [itpd_pkg::HIGH_W-1:0]    high;
} trace_pkt_t;

class itm_item_scoreboard;
    logic [itpd_pkg::PRESCALE_W-1:0] prescale;
    itpd_pkg::sync_state_t           sync;
    itpd_pkg::cause_t                cause;
    logic [itpd_pkg::TS_W-1:0]       local_ts;
    logic [itpd_pkg::TS_W-1:0]       global_ts;
    logic [7:0]                      page;
    bit                              await_high;
    bit                              ovf_pending;
    bit                              freq_pending;
    itpd_pkg::result_t               pending_items[$];
    int                              errors;

    function new();
        prescale = 1;
        cause    = itpd_pkg::CAUSE_INIT;
        errors   = 0;
        clear_decoder();
    endfunction

    function void clear_decoder();
        sync         = itpd_pkg::SYNC_NONE;
        local_ts     = '0;
        global_ts    = '0;
        page         = '0;
        await_high   = 1'b1;
        ovf_pending  = 1'b0;
        freq_pending = 1'b0;
    endfunction

    function void set_prescale(logic [itpd_pkg::PRESCALE_W-1:0] v);
        prescale = v;
    endfunction

    function bit is_decoding();
        return sync == itpd_pkg::SYNC_DECODE;
    endfunction

    function int pending();
        return pending_items.size();
    endfunction

    function void fill_itm(inout itpd_pkg::result_t r, input itpd_pkg::itm_kind_t k,
                           input logic [2:0] sz,
                           input logic [itpd_pkg::PAYLOAD_W-1:0] v, input logic [7:0] s);
        r.item_kind     = itpd_pkg::IK_ITM;
        r.itm_kind      = k;
        r.out_size      = sz;
        r.out_value     = v;
        r.out_source    = s;
        r.overflow_seen = ovf_pending;
        ovf_pending     = 1'b0;
    endfunction

    function void fill_global(inout itpd_pkg::result_t r);
        fill_itm(r, itpd_pkg::ITK_TS_GLOBAL, 3'd0, '0, 8'h00);
        r.timestamp       = global_ts;
        r.timestamp_valid = 1'b1;
        r.freq_changed    = freq_pending;
        freq_pending      = 1'b0;
    endfunction

    function bit decode_packet(input trace_pkt_t p, output itpd_pkg::result_t r);
        logic [itpd_pkg::TS_W-1:0] mask;
        r = '0;
        case (p.kind)
            itpd_pkg::PK_NOTSYNC:
            begin
                clear_decoder();
                return 0;
            end
            itpd_pkg::PK_ASYNC, itpd_pkg::PK_INC_EOT: return 0;
            itpd_pkg::PK_DWT:
            begin
                fill_itm(r, itpd_pkg::ITK_DWT, p.nbytes, p.payload, p.source);
                return 1;
            end
            itpd_pkg::PK_SWIT:
            begin
                fill_itm(r, itpd_pkg::ITK_SWIT, p.nbytes, p.payload,
                         {page[2:0], p.source[4:0]});
                return 1;
            end
            itpd_pkg::PK_EXTENSION:
            begin
                if (!p.source[7] && p.source[4:0] == itpd_pkg::EXT_PAGE_CODE)
                    page = p.payload[7:0];
                return 0;
            end
            itpd_pkg::PK_OVERFLOW:
            begin
                local_ts    = '0;
                ovf_pending = 1'b1;
                return 0;
            end
            itpd_pkg::PK_GTS1:
            begin
                if (p.source[GTS1_WAIT_BIT])
                    await_high = 1'b1;
                if (p.source[GTS1_FREQ_BIT])
                    freq_pending = 1'b1;
                case (p.nbytes)
                    3'd0, 3'd1: mask = itpd_pkg::GTS_MASK_1;
                    3'd2:       mask = itpd_pkg::GTS_MASK_2;
                    3'd3:       mask = itpd_pkg::GTS_MASK_3;
                    default:    mask = itpd_pkg::GTS_MASK_4;
                endcase
                // the whole payload goes in, not only the masked bits
                global_ts = (global_ts & ~mask) | itpd_pkg::TS_W'(p.payload);
                if (await_high)
                    return 0;
                fill_global(r);
                return 1;
            end
            itpd_pkg::PK_GTS2:
            begin
                global_ts = (global_ts & itpd_pkg::GTS_MASK_4)
                            | (itpd_pkg::TS_W'(p.high) << itpd_pkg::GTS_SHIFT);
                fill_global(r);
                await_high = 1'b0;
                return 1;
            end
            itpd_pkg::PK_LOCAL_TS:
            begin
                local_ts = local_ts + itpd_pkg::TS_W'(p.payload) * itpd_pkg::TS_W'(prescale);
                fill_itm(r, itpd_pkg::itm_kind_t'(itpd_pkg::ITK_LOCAL_BASE
                                                  + {1'b0, p.source[1:0]}),
                         p.nbytes, p.payload, 8'h00);
                r.timestamp       = local_ts;
                r.timestamp_valid = 1'b1;
                return 1;
            end
            default:
            begin
                cause = itpd_pkg::CAUSE_BAD;
                clear_decoder();
                r.item_kind     = itpd_pkg::IK_FATAL;
                r.unsync_reason = itpd_pkg::CAUSE_BAD;
                return 1;
            end
        endcase
    endfunction

    function void note_packet(trace_pkt_t p);
        itpd_pkg::result_t r;
        bit                emit;
        r    = '0;
        emit = 0;
        case (p.action)
            itpd_pkg::ACT_EOT:
            begin
                r.item_kind     = itpd_pkg::IK_EOT;
                r.unsync_reason = itpd_pkg::CAUSE_EOT;
                emit            = 1;
            end
            itpd_pkg::ACT_RESET: cause = itpd_pkg::CAUSE_RESET;
            itpd_pkg::ACT_PACKET:
            begin
                if (sync == itpd_pkg::SYNC_DECODE)
                begin
                    emit = decode_packet(p, r);
                end
                else
                begin
                    if (sync == itpd_pkg::SYNC_NONE)
                    begin
                        r.item_kind     = itpd_pkg::IK_NO_SYNC;
                        r.unsync_reason = cause;
                        sync            = itpd_pkg::SYNC_WAIT;
                        emit            = 1;
                    end
                    if (p.kind == itpd_pkg::PK_ASYNC)
                        sync = itpd_pkg::SYNC_DECODE;
                end
            end
            default: ;
        endcase
        if (emit)
            pending_items.push_back(r);
    endfunction

    function string show(itpd_pkg::result_t r);
        return $sformatf({"kind=%0d rsn=%0d itk=%0d size=%0d val=%h src=%h ",
                          "ovf=%0b ts=%h tsv=%0b fc=%0b"},
                         r.item_kind, r.unsync_reason, r.itm_kind, r.out_size, r.out_value,
                         r.out_source, r.overflow_seen, r.timestamp, r.timestamp_valid,
                         r.freq_changed);
    endfunction

    function void check_item(itpd_pkg::result_t got);
        itpd_pkg::result_t want;
        if (pending_items.size() == 0)
        begin
            if (errors < 10)
                $display("%0t: unexpected item: %s", $realtime, show(got));
            errors++;
            return;
        end
        want = pending_items.pop_front();
        if (got.item_kind !== want.item_kind || got.unsync_reason !== want.unsync_reason ||
            got.itm_kind !== want.itm_kind || got.out_size !== want.out_size ||
            got.out_value !== want.out_value || got.out_source !== want.out_source ||
            got.overflow_seen !== want.overflow_seen || got.timestamp !== want.timestamp ||
            got.timestamp_valid !== want.timestamp_valid ||
            got.freq_changed !== want.freq_changed)
        begin
            if (errors < 10)
            begin
                $display("%0t: item mismatch", $realtime);
                $display("  expected %s", show(want));
                $display("  actual   %s", show(got));
            end
            errors++;
        end
    endfunction
endclass

module tb_itm_trace_packet_decoder;

    logic clk;
    logic rst_n;
    bit   steady;

    itpd_pkt_if  pkt_bus();
    itpd_cfg_if  cfg_bus();
    itpd_item_if item_bus();

    itm_item_scoreboard sb;

    itm_trace_packet_decoder uut (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt_bus),
        .cfg   (cfg_bus),
        .item  (item_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // result side backpressure
    initial
    begin
        item_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            item_bus.ready <= steady || ($urandom_range(0, 99) >= 31);
        end
    end

    always @(posedge clk)
    begin : result_monitor
        itpd_pkg::result_t got;
        if (rst_n && item_bus.valid && item_bus.ready)
        begin
            got.item_kind       = item_bus.item_kind;
            got.unsync_reason   = item_bus.unsync_reason;
            got.itm_kind        = item_bus.itm_kind;
            got.out_size        = item_bus.out_size;
            got.out_value       = item_bus.out_value;
            got.out_source      = item_bus.out_source;
            got.overflow_seen   = item_bus.overflow_seen;
            got.timestamp       = item_bus.timestamp;
            got.timestamp_valid = item_bus.timestamp_valid;
            got.freq_changed    = item_bus.freq_changed;
            sb.check_item(got);
        end
    end

    function automatic trace_pkt_t mk(logic [1:0] action, logic [3:0] kind,
                                      logic [7:0] source = 8'h00,
                                      logic [itpd_pkg::PAYLOAD_W-1:0] payload = '0,
                                      logic [2:0] nbytes = 3'd1,
                                      logic [itpd_pkg::HIGH_W-1:0] high = '0);
        trace_pkt_t p;
        p.action  = action;
        p.kind    = kind;
        p.source  = source;
        p.payload = payload;
        p.nbytes  = nbytes;
        p.high    = high;
        return p;
    endfunction

    task automatic send_packet(trace_pkt_t p);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 31)
        begin
            pkt_bus.valid <= 1'b0;
            @(negedge clk);
        end
        pkt_bus.valid         <= 1'b1;
        pkt_bus.action        <= p.action;
        pkt_bus.packet_kind   <= p.kind;
        pkt_bus.source_id     <= p.source;
        pkt_bus.payload       <= p.payload;
        pkt_bus.payload_bytes <= p.nbytes;
        pkt_bus.high_value    <= p.high;
        do
            @(posedge clk);
        while (!pkt_bus.ready);
        sb.note_packet(p);
    endtask

    // hold off until the pipeline is empty
    task automatic drain();
        @(negedge clk);
        pkt_bus.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_prescale(logic [itpd_pkg::PRESCALE_W-1:0] v);
        drain();
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= v;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        sb.set_prescale(v);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic trace_pkt_t random_packet();
        trace_pkt_t p;
        int         roll;
        int         pick;
        p.action  = itpd_pkg::ACT_PACKET;
        p.source  = 8'($urandom);
        p.payload = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 255)) : $urandom;
        p.nbytes  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                : 3'($urandom_range(1, 4));
        p.high    = {6'($urandom), 32'($urandom)};
        p.kind    = itpd_pkg::PK_ASYNC;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            p.action = itpd_pkg::ACT_EOT;
        else if (roll < 5)
            p.action = itpd_pkg::ACT_RESET;
        else if (roll < 6)
            p.action = ACT_UNUSED;
        if (p.action != itpd_pkg::ACT_PACKET || !sb.is_decoding())
        begin
            if ($urandom_range(0, 3) == 0)
                p.kind = 4'($urandom_range(0, 15));
            return p;
        end
        pick = $urandom_range(0, 99);
        if (pick < 2)
            p.kind = itpd_pkg::PK_NOTSYNC;
        else if (pick < 5)
            p.kind = 4'($urandom_range(PK_BAD, PK_RESERVED_TOP));
        else if (pick < 7)
            p.kind = ($urandom_range(0, 1) != 0) ? itpd_pkg::PK_ASYNC : itpd_pkg::PK_INC_EOT;
        else if (pick < 25)
            p.kind = itpd_pkg::PK_SWIT;
        else if (pick < 36)
            p.kind = itpd_pkg::PK_DWT;
        else if (pick < 46)
        begin
            p.kind = itpd_pkg::PK_EXTENSION;
            // mostly well-formed page extensions
            if ($urandom_range(0, 9) < 7)
                p.source = {1'b0, 2'($urandom), itpd_pkg::EXT_PAGE_CODE};
        end
        else if (pick < 52)
            p.kind = itpd_pkg::PK_OVERFLOW;
        else if (pick < 66)
            p.kind = itpd_pkg::PK_GTS1;
        else if (pick < 76)
            p.kind = itpd_pkg::PK_GTS2;
        else
            p.kind = itpd_pkg::PK_LOCAL_TS;
        return p;
    endfunction

    initial
    begin
        logic [itpd_pkg::PRESCALE_W-1:0] phase_scale [7];
        int                              sent;
        trace_pkt_t                      p;

        sb     = new();
        steady = 1'b0;
        rst_n  = 1'b0;
        pkt_bus.valid         = 1'b0;
        pkt_bus.action        = itpd_pkg::ACT_PACKET;
        pkt_bus.packet_kind   = itpd_pkg::PK_NOTSYNC;
        pkt_bus.source_id     = '0;
        pkt_bus.payload       = '0;
        pkt_bus.payload_bytes = '0;
        pkt_bus.high_value    = '0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.data          = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_prescale(7'd5);

        // out of sync handling, then each packet kind and field extreme
        send_packet(mk(itpd_pkg::ACT_PACKET, itpd_pkg::PK_SWIT));
        send_packet(mk(itpd_pkg::ACT_PACKET, itpd_pkg::PK_DWT, 8'hFF, '1, 3'd4));
        send_packet(mk(itpd_pkg::ACT_PACKET, itpd_pkg::PK_ASYNC));
        send_packet(mk(itpd_pkg::ACT_PACKET, itpd_pkg::PK_SWIT, 8'hFF, '1, 3'd4));
        send_packet(mk(itpd_pkg::ACT_PACKET, itpd_pkg::PK_EXTENSION, 8'h02, 32'h0000_00AB));
        send_packet(mk(itpd_pkg::ACT_PACKET, itpd_pkg::PK_SWIT, 8'h1F, '0, 3'd1));
        send_packet(mk(itpd_pkg::ACT_PACKET, itpd_pkg::PK_EXTENSION, 8'h82, 32'h0000_00FF));
        send_packet(mk(itpd_pkg::ACT_PACKET, itpd_pkg::PK_EXTENSION, 8'h62, 32'hFFFF_FF05));
        send_packet(mk(itpd_pkg::ACT_PACKET, itpd_pkg::PK_DWT, 8'hFF, '0, 3'd7));
        send_packet(mk(itpd_pkg::ACT_PACKET, itpd_pkg::PK_OVERFLOW));
        send_packet(mk(itpd_pkg::ACT_PACKET, itpd_pkg::PK_LOCAL_TS, 8'h03, '1, 3'd4));
        send_packet(mk(itpd_pkg::ACT_PACKET, itpd_pkg::PK_LOCAL_TS, 8'h00, 32'd5, 3'd0));
        send_packet(mk(itpd_pkg::ACT_PACKET, itpd_pkg::PK_GTS1, 8'h03, '1, 3'd0));
        send_packet(mk(itpd_pkg::ACT_PACKET, itpd_pkg::PK_GTS2, 8'h00, '0, 3'd1, '1));
        send_packet(mk(itpd_pkg::ACT_PACKET, itpd_pkg::PK_GTS1, 8'h00, 32'h0001_2345, 3'd2));
        send_packet(mk(itpd_pkg::ACT_PACKET, itpd_pkg::PK_GTS1, 8'h00, '0, 3'd7));
        send_packet(mk(itpd_pkg::ACT_PACKET, itpd_pkg::PK_GTS2));
        send_packet(mk(itpd_pkg::ACT_PACKET, itpd_pkg::PK_INC_EOT));
        send_packet(mk(itpd_pkg::ACT_EOT, itpd_pkg::PK_SWIT));
        send_packet(mk(ACT_UNUSED, itpd_pkg::PK_SWIT));
        send_packet(mk(itpd_pkg::ACT_RESET, itpd_pkg::PK_SWIT));
        send_packet(mk(itpd_pkg::ACT_PACKET, itpd_pkg::PK_NOTSYNC));
        send_packet(mk(itpd_pkg::ACT_PACKET, itpd_pkg::PK_SWIT));
        send_packet(mk(itpd_pkg::ACT_PACKET, itpd_pkg::PK_ASYNC));
        send_packet(mk(itpd_pkg::ACT_PACKET, PK_BAD));
        send_packet(mk(itpd_pkg::ACT_PACKET, PK_RESERVED_TOP));
        send_packet(mk(itpd_pkg::ACT_PACKET, itpd_pkg::PK_ASYNC));
        send_packet(mk(itpd_pkg::ACT_PACKET, PK_RESERVED_LOW));

        phase_scale[0] = 7'd64;
        phase_scale[1] = 7'd1;
        phase_scale[2] = 7'd127;
        phase_scale[3] = 7'd0;
        phase_scale[4] = 7'($urandom_range(1, 64));
        phase_scale[5] = 7'($urandom_range(1, 64));
        phase_scale[6] = 7'd64;
        for (int ph = 0; ph < 7; ph++)
        begin
            write_prescale(phase_scale[ph]);
            steady = (ph == 2);
            sent   = 0;
            while (sent < 250)
            begin
                p = random_packet();
                send_packet(p);
                if (p.action != ACT_UNUSED)
                    sent++;
            end
        end
        steady = 1'b0;

        drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/itpd_pkg.sv
rtl/core/itpd_if.sv
rtl/core/itpd_in_stage.sv
rtl/core/itpd_decode.sv
rtl/core/itm_trace_packet_decoder.sv
rtl/core/itpd_checker.sv
sim/tb_itm_trace_packet_decoder.sv
